FILE: design/text_glyph_rasterizer_assert.svh
// Assertion helpers used by the rasterizer RTL (tgr_back).
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef TEXT_GLYPH_RASTERIZER_ASSERT_SVH
`define TEXT_GLYPH_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define TGR_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked out of reset only.
`define TGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: design/tgr_pkg.sv
`timescale 1ns / 1ps
package tgr_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] LAST_CODE    = 8'd126;
  localparam int GLYPH_W = 4;
  localparam int GLYPH_H = 8;
  localparam int GLYPH_PIX = GLYPH_W * GLYPH_H;
  localparam int FONT_N = 95;
  localparam logic signed [14:0] PEN_MAX = 15'sd8184;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_FG_COLOR      = 3'd2,
    REG_FILL_COLOR    = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_ROW_PITCH     = 3'd6,
    REG_ENABLE        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic [31:0]        fg_color;
    logic [31:0]        fill_color;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
    logic [13:0]        row_pitch_pixels;
    logic               enable;
  } cfg_t;

  // One character's drawing job; bit i of glyph/mask is row i/4, column i%4.
  typedef struct packed {
    logic signed [13:0]   pen_x;
    logic signed [13:0]   pen_y;
    logic [GLYPH_PIX-1:0] glyph;
    logic [GLYPH_PIX-1:0] mask;
  } job_t;

  typedef struct packed {
    logic [24:0] offset;
    logic [31:0] value;
    logic        last;
  } pix_t;

  // Four bytes per glyph, first byte in the top bits; each byte holds two rows,
  // upper nibble first, bit 3 of a nibble is the leftmost pixel.
  localparam logic [31:0] FONT_ROM [0:FONT_N-1] = '{
    32'h00000000, 32'h44444404, 32'hAAAA0000, 32'hAAFFAAFF,
    32'h4EA42A72, 32'h88228822, 32'h44AA44AA, 32'h44440000,
    32'h24444424, 32'h42222242, 32'h44FF44FF, 32'h044E0400,
    32'h00004424, 32'h000E0000, 32'h00000044, 32'h08842201,
    32'h44AAAA44, 32'h24242424, 32'h4E228EEE, 32'h4E26224E,
    32'hA4AE2424, 32'hEE8E224E, 32'h4E8AAE4E, 32'hEE224444,
    32'h4EAEAA4E, 32'h4EAE224E, 32'h00440044, 32'h00440024,
    32'h22444422, 32'h0E000E00, 32'h44222244, 32'h4E220404,
    32'h4EBA8A4E, 32'h44AAAEAA, 32'hCEAAACEE, 32'h4E88884E,
    32'hCEAAAACE, 32'hEE8E88EE, 32'hEE8E8888, 32'h4E8AAA4E,
    32'hAAAEAAAA, 32'hEE4444EE, 32'h2222AA44, 32'hAAACACAA,
    32'h888888EE, 32'hAAEAAAAA, 32'hAABA9AAA, 32'h44AAAA44,
    32'hCEAAAC88, 32'h44AABA42, 32'hCEAAACAA, 32'h4E8A244E,
    32'hEE444444, 32'hAAAAAA4E, 32'hAAAA4444, 32'hAAAAEAAA,
    32'hAA4444AA, 32'hAA444444, 32'hEE2484EE, 32'h6E88886E,
    32'h88442211, 32'h6E22226E, 32'h4AAA0000, 32'h000000EE,
    32'h44220000, 32'h004EAE4A, 32'h88CEAACE, 32'h004E884E,
    32'h224EAE4E, 32'h004EAE46, 32'h244E4444, 32'h004EAE4E,
    32'h88CEAAAA, 32'h0404444E, 32'h02022A44, 32'h88ACACAA,
    32'h44444444, 32'h00EAAAAA, 32'h00CEAAAA, 32'h0044AA44,
    32'h00CEAACE, 32'h004EAE4E, 32'h00CE8888, 32'h004E4E4E,
    32'h444E4424, 32'h00AAAA4E, 32'h00AA4444, 32'h00AAEAAA,
    32'h00AA44AA, 32'h00AA4444, 32'h00EE44EE, 32'h24444424,
    32'h44444444, 32'h44222244, 32'h2AA40000
  };

  function automatic logic is_printable(input logic [7:0] code);
    return (code >= FIRST_CODE) && (code <= LAST_CODE);
  endfunction

  // Glyph bits in pixel order (bit 0 = top-left); zero for codes without a glyph.
  function automatic logic [GLYPH_PIX-1:0] glyph_bits(input logic [7:0] code);
    logic [7:0]           idx;
    logic [31:0]          word;
    logic [GLYPH_PIX-1:0] bits;
    idx  = code - FIRST_CODE;
    word = '0;
    if (is_printable(code)) begin
      word = FONT_ROM[idx[6:0]];
    end
    for (int i = 0; i < GLYPH_PIX; i++) begin
      bits[i] = word[GLYPH_PIX-1-i];
    end
    return bits;
  endfunction

  // Pen step with saturation at the right/bottom limit.
  function automatic logic signed [13:0] pen_advance(input logic signed [13:0] v,
                                                     input logic [3:0] step);
    logic signed [14:0] sum;
    sum = {v[13], v} + $signed({11'b0, step});
    if (sum > PEN_MAX) begin
      return PEN_MAX[13:0];
    end
    return sum[13:0];
  endfunction

endpackage

FILE: design/text_glyph_rasterizer.sv
`timescale 1ns / 1ps
// 4x8 bitmap font character generator. Each accepted character code moves a
// pen; printable codes (32..126) turn into pixel writes, one result per pixel
// that lands inside the screen (fg color for set glyph bits, bg color for clear
// bits unless bg is zero), in row-major order, with last_of_char on the final
// write of the character. Newline returns the pen to origin x and drops it 8
// rows. Offsets are y*row_pitch_pixels + x modulo 2^25, relative to the frame
// buffer base. Throughput: one pixel write per clock unless the full result
// queue stalls the back end; the single pixel issue slot of the back end sets
// it. A character makes 0 to 32 writes; one with none is dropped at the front
// and only moves the pen. The first write passes the job queue, current job,
// stages 1 and 2 and the result queue. Configuration writes take effect at
// once and belong only between strings, with the block drained.
module text_glyph_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // characters in
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_start_of_string,
  // pixel writes out
  output logic        empty,
  input  logic        pop,
  output logic [24:0] out_pixel_offset,
  output logic [31:0] out_pixel_value,
  output logic        out_last_of_char
);

  tgr_pkg::cfg_t cfg_r;
  tgr_pkg::job_t fe_job, jq_job;
  tgr_pkg::pix_t pix;
  logic          fe_push, jq_full, jq_valid, jq_pop;

  // Register file: write-only, reset to the documented defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x         <= '0;
      cfg_r.origin_y         <= '0;
      cfg_r.fg_color         <= 32'hFFFF_FFFF;
      cfg_r.fill_color       <= '0;
      cfg_r.screen_width     <= '0;
      cfg_r.screen_height    <= '0;
      cfg_r.row_pitch_pixels <= 14'd1;
      cfg_r.enable           <= 1'b0;
    end else if (cfg_we) begin
      case (tgr_pkg::reg_idx_t'(cfg_index))
        tgr_pkg::REG_ORIGIN_X:      cfg_r.origin_x         <= cfg_wdata[12:0];
        tgr_pkg::REG_ORIGIN_Y:      cfg_r.origin_y         <= cfg_wdata[12:0];
        tgr_pkg::REG_FG_COLOR:      cfg_r.fg_color         <= cfg_wdata;
        tgr_pkg::REG_FILL_COLOR:    cfg_r.fill_color       <= cfg_wdata;
        tgr_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width     <= cfg_wdata[12:0];
        tgr_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height    <= cfg_wdata[12:0];
        tgr_pkg::REG_ROW_PITCH:     cfg_r.row_pitch_pixels <= cfg_wdata[13:0];
        tgr_pkg::REG_ENABLE:        cfg_r.enable           <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Front: track the pen, look up the glyph, clip, and build the write mask.
  tgr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .push            (push),
    .char_code       (in_char_code),
    .start_of_string (in_start_of_string),
    .full            (full),
    .jq_full         (jq_full),
    .jq_push         (fe_push),
    .jq_job          (fe_job)
  );

  // Two-entry job queue decouples pen tracking from pixel issue.
  tgr_job_queue u_job_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fe_push),
    .job_in  (fe_job),
    .full    (jq_full),
    .valid   (jq_valid),
    .job_out (jq_job),
    .pop     (jq_pop)
  );

  // Back: walk the mask one pixel per cycle unless the result queue stalls it, compute offsets, hold results.
  tgr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .jq_valid (jq_valid),
    .jq_job   (jq_job),
    .jq_pop   (jq_pop),
    .empty    (empty),
    .pop      (pop),
    .pix      (pix)
  );

  assign out_pixel_offset = pix.offset;
  assign out_pixel_value  = pix.value;
  assign out_last_of_char = pix.last;

endmodule

FILE: design/tgr_front.sv
`timescale 1ns / 1ps
module tgr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  tgr_pkg::cfg_t cfg,
  input  logic          push,
  input  logic [7:0]    char_code,
  input  logic          start_of_string,
  output logic          full,
  input  logic          jq_full,
  output logic          jq_push,
  output tgr_pkg::job_t jq_job
);

  logic signed [13:0] pen_x_r, pen_x_nxt;
  logic signed [13:0] pen_y_r, pen_y_nxt;
  logic signed [13:0] px0, py0;
  logic               accept;
  logic               draw;
  logic [tgr_pkg::GLYPH_W-1:0] col_ok;
  logic [tgr_pkg::GLYPH_H-1:0] row_ok;
  logic [tgr_pkg::GLYPH_PIX-1:0] glyph;
  logic [tgr_pkg::GLYPH_PIX-1:0] mask;
  logic signed [14:0] xs, ys;
  logic               bg_on;

  assign full   = jq_full;
  assign accept = push && !jq_full;

  // Start of string moves the pen to the origin before anything else.
  assign px0 = start_of_string ? {cfg.origin_x[12], cfg.origin_x} : pen_x_r;
  assign py0 = start_of_string ? {cfg.origin_y[12], cfg.origin_y} : pen_y_r;

  assign glyph = tgr_pkg::glyph_bits(char_code);
  assign draw  = cfg.enable && tgr_pkg::is_printable(char_code);
  assign bg_on = (cfg.fill_color != '0);

  always_comb begin
    xs = '0;
    ys = '0;
    for (int c = 0; c < tgr_pkg::GLYPH_W; c++) begin
      xs = {px0[13], px0} + 15'(c);
      col_ok[c] = !xs[14] && (xs[13:0] < {1'b0, cfg.screen_width});
    end
    for (int r = 0; r < tgr_pkg::GLYPH_H; r++) begin
      ys = {py0[13], py0} + 15'(r);
      row_ok[r] = !ys[14] && (ys[13:0] < {1'b0, cfg.screen_height});
    end
    for (int i = 0; i < tgr_pkg::GLYPH_PIX; i++) begin
      mask[i] = draw && col_ok[i % tgr_pkg::GLYPH_W] && row_ok[i / tgr_pkg::GLYPH_W]
                && (glyph[i] || bg_on);
    end
  end

  always_comb begin
    if (char_code == tgr_pkg::NEWLINE_CODE) begin
      pen_x_nxt = {cfg.origin_x[12], cfg.origin_x};
      pen_y_nxt = tgr_pkg::pen_advance(py0, 4'(tgr_pkg::GLYPH_H));
    end else begin
      pen_x_nxt = tgr_pkg::pen_advance(px0, 4'(tgr_pkg::GLYPH_W));
      pen_y_nxt = py0;
    end
  end

  // Drop characters that write nothing; they only move the pen.
  assign jq_push      = accept && (mask != '0);
  assign jq_job.pen_x = px0;
  assign jq_job.pen_y = py0;
  assign jq_job.glyph = glyph;
  assign jq_job.mask  = mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else if (accept) begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

FILE: design/tgr_job_queue.sv
`timescale 1ns / 1ps
module tgr_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tgr_pkg::job_t job_in,
  output logic          full,
  output logic          valid,
  output tgr_pkg::job_t job_out,
  input  logic          pop
);

  tgr_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign job_out = mem_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= job_in;
    end
  end

endmodule

FILE: design/tgr_back.sv
`timescale 1ns / 1ps
`include "text_glyph_rasterizer_assert.svh"
module tgr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tgr_pkg::cfg_t cfg,
  input  logic          jq_valid,
  input  tgr_pkg::job_t jq_job,
  output logic          jq_pop,
  output logic          empty,
  input  logic          pop,
  output tgr_pkg::pix_t pix
);

  // Current job, lowest set mask bit goes next.
  logic          cur_v_r, cur_v_nxt;
  tgr_pkg::job_t cur_r;
  logic [tgr_pkg::GLYPH_PIX-1:0] rem;
  logic [4:0]    idx;
  logic          last, issue;

  // Stage 1: pixel coordinates. Stage 2: row product.
  logic        s1_v_r, s2_v_r;
  logic [12:0] s1_x_r, s1_y_r, s2_x_r;
  logic [31:0] s1_color_r, s2_color_r;
  logic        s1_last_r, s2_last_r;
  logic [24:0] s2_prod_r;
  logic [26:0] prod;
  logic        s1_rdy, s2_rdy, s1_move;

  // Result queue.
  tgr_pkg::pix_t oq_mem_r [tgr_pkg::OQ_DEPTH];
  logic [tgr_pkg::OQ_PTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [tgr_pkg::OQ_CNT_W-1:0] oq_cnt_r;
  logic oq_full, oq_push, oq_pop;

  always_comb begin
    idx = '0;
    for (int i = tgr_pkg::GLYPH_PIX - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) idx = 5'(i);
    end
  end

  assign rem  = cur_r.mask & (cur_r.mask - 1'b1);
  assign last = (rem == '0);

  assign oq_full = (oq_cnt_r == tgr_pkg::OQ_CNT_W'(tgr_pkg::OQ_DEPTH));
  assign oq_push = s2_v_r && !oq_full;
  assign oq_pop  = pop && !empty;
  assign empty   = (oq_cnt_r == '0);
  assign pix     = oq_mem_r[oq_rp_r];

  assign s2_rdy  = !s2_v_r || !oq_full;
  assign s1_move = s1_v_r && s2_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign issue   = cur_v_r && s1_rdy;
  assign jq_pop  = jq_valid && (!cur_v_r || (issue && last));

  always_comb begin
    cur_v_nxt = cur_v_r;
    if (jq_pop) begin
      cur_v_nxt = 1'b1;
    end else if (issue && last) begin
      cur_v_nxt = 1'b0;
    end
  end

  assign prod = s1_y_r * cfg.row_pitch_pixels;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r  <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      cur_v_r <= cur_v_nxt;
      if (s1_rdy) s1_v_r <= issue;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (oq_push) oq_wp_r <= oq_wp_r + 1'b1;
      if (oq_pop)  oq_rp_r <= oq_rp_r + 1'b1;
      oq_cnt_r <= oq_cnt_r + tgr_pkg::OQ_CNT_W'(oq_push) - tgr_pkg::OQ_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      cur_r <= jq_job;
    end else if (issue) begin
      cur_r.mask <= rem;
    end
    if (issue) begin
      s1_x_r     <= cur_r.pen_x[12:0] + {11'b0, idx[1:0]};
      s1_y_r     <= cur_r.pen_y[12:0] + {10'b0, idx[4:2]};
      s1_color_r <= cur_r.glyph[idx] ? cfg.fg_color : cfg.fill_color;
      s1_last_r  <= last;
    end
    if (s1_move) begin
      s2_prod_r  <= prod[24:0];
      s2_x_r     <= s1_x_r;
      s2_color_r <= s1_color_r;
      s2_last_r  <= s1_last_r;
    end
    if (oq_push) begin
      oq_mem_r[oq_wp_r].offset <= s2_prod_r + {12'b0, s2_x_r};
      oq_mem_r[oq_wp_r].value  <= s2_color_r;
      oq_mem_r[oq_wp_r].last   <= s2_last_r;
    end
  end

  `TGR_ASSERT_HOLDS(a_cur_job_has_work, cur_v_r, cur_r.mask != '0)
  `TGR_ASSERT_HOLDS(a_oq_cnt_bound, 1'b1,
                    oq_cnt_r <= tgr_pkg::OQ_CNT_W'(tgr_pkg::OQ_DEPTH))
  `TGR_ASSERT_NEXT(a_last_drains_job, issue && last && !jq_valid, !cur_v_r)
  `TGR_ASSERT_NEXT(a_push_lands, oq_push, oq_cnt_r != '0)

endmodule
